FILE: rtl/ckb_pkg.sv
// ----------------------------------------------------------------------------
// ckb_pkg
// Types and constants shared by the color-keyed sprite blitter files.
// ----------------------------------------------------------------------------
package ckb_pkg;

  localparam int PIXEL_W  = 8;
  localparam int ORIGIN_W = 11;
  localparam int SIZE_W   = 7;
  localparam int ADDR_W   = 17;
  // Screen positions are kept signed and wide enough for any origin plus
  // offset and for screen limits up to 4096.
  localparam int POS_W    = 14;

  localparam logic [PIXEL_W-1:0] TRANSPARENT = '0;

  typedef struct packed {
    logic [PIXEL_W-1:0]         pixel;
    logic                       start_req;
    logic signed [ORIGIN_W-1:0] origin_x;
    logic signed [ORIGIN_W-1:0] origin_y;
    logic [SIZE_W-1:0]          sprite_size;
  } pix_t;

  typedef struct packed {
    logic signed [POS_W-1:0] sx;
    logic signed [POS_W-1:0] sy;
  } pos_t;

endpackage

FILE: rtl/ckb_ifs.sv
// ----------------------------------------------------------------------------
// ckb_ifs
// Valid/ready channels for sprite pixels in and frame-buffer writes out.
// ----------------------------------------------------------------------------
interface ckb_pix_if;
  logic                                valid;
  logic                                ready;
  logic [ckb_pkg::PIXEL_W-1:0]         pixel;
  logic                                start_req;
  logic signed [ckb_pkg::ORIGIN_W-1:0] origin_x;
  logic signed [ckb_pkg::ORIGIN_W-1:0] origin_y;
  logic [ckb_pkg::SIZE_W-1:0]          sprite_size;

  modport source (output valid, pixel, start_req, origin_x, origin_y, sprite_size,
                  input ready);
  modport sink   (input valid, pixel, start_req, origin_x, origin_y, sprite_size,
                  output ready);
  modport mon    (input valid, ready, pixel, start_req, origin_x, origin_y,
                  sprite_size);
endinterface

interface ckb_wr_if;
  logic                        valid;
  logic                        ready;
  logic [ckb_pkg::ADDR_W-1:0]  write_address;
  logic [ckb_pkg::PIXEL_W-1:0] write_data;

  modport source (output valid, write_address, write_data, input ready);
  modport sink   (input valid, write_address, write_data, output ready);
  modport mon    (input valid, ready, write_address, write_data);
endinterface

FILE: rtl/ckb_tracker.sv
// ----------------------------------------------------------------------------
// ckb_tracker
// Holds the latched placement and the column and row counters, and gives the
// screen position of the pixel now being processed.
// ----------------------------------------------------------------------------
module ckb_tracker #(
  parameter int MAX_SPRITE = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  ckb_pkg::pix_t pix,
  output ckb_pkg::pos_t pos
);

  localparam int CW = (MAX_SPRITE > 1) ? $clog2(MAX_SPRITE) : 1;
  localparam int SW = $clog2(MAX_SPRITE + 1);

  logic [CW-1:0]                       col_r, col_nxt, row_r, row_nxt;
  logic signed [ckb_pkg::ORIGIN_W-1:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic [SW-1:0]                       size_r, size_nxt;
  logic [CW-1:0]                       col_eff, row_eff;
  logic [8:0]                          req_size;
  logic [SW-1:0]                       clamp_size;
  logic [SW:0]                         col_inc, row_inc;

  always_comb begin
    req_size = {2'b00, pix.sprite_size};
    if (req_size == 9'd0) begin
      clamp_size = SW'(1);
    end else if (req_size > 9'(MAX_SPRITE)) begin
      clamp_size = SW'(MAX_SPRITE);
    end else begin
      clamp_size = req_size[SW-1:0];
    end

    if (pix.start_req) begin
      ox_nxt   = pix.origin_x;
      oy_nxt   = pix.origin_y;
      size_nxt = clamp_size;
      col_eff  = '0;
      row_eff  = '0;
    end else begin
      ox_nxt   = ox_r;
      oy_nxt   = oy_r;
      size_nxt = size_r;
      col_eff  = col_r;
      row_eff  = row_r;
    end

    pos.sx = ckb_pkg::POS_W'(ox_nxt) + $signed({{(ckb_pkg::POS_W-CW){1'b0}}, col_eff});
    pos.sy = ckb_pkg::POS_W'(oy_nxt) + $signed({{(ckb_pkg::POS_W-CW){1'b0}}, row_eff});

    col_inc = (SW+1)'(col_eff) + (SW+1)'(1);
    row_inc = (SW+1)'(row_eff) + (SW+1)'(1);
    col_nxt = col_inc[CW-1:0];
    row_nxt = row_eff;
    if (col_inc >= {1'b0, size_nxt}) begin
      col_nxt = '0;
      row_nxt = row_inc[CW-1:0];
      if (row_inc >= {1'b0, size_nxt}) begin
        row_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      ox_r   <= '0;
      oy_r   <= '0;
      size_r <= SW'(1);
    end else if (step) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      ox_r   <= ox_nxt;
      oy_r   <= oy_nxt;
      size_r <= size_nxt;
    end
  end

endmodule

FILE: rtl/ckb_clip.sv
// ----------------------------------------------------------------------------
// ckb_clip
// Color key and screen clipping test, and frame-buffer address forming.
// ----------------------------------------------------------------------------
module ckb_clip #(
  parameter int SCREEN_WIDTH  = 512,
  parameter int SCREEN_HEIGHT = 200
) (
  input  ckb_pkg::pos_t                pos,
  input  logic [ckb_pkg::PIXEL_W-1:0]  pixel,
  output logic                         hit,
  output logic [ckb_pkg::ADDR_W-1:0]   addr
);

  localparam int PW = 2 * ckb_pkg::POS_W;

  logic          in_x, in_y;
  logic [PW-1:0] prod;

  always_comb begin
    in_x = !pos.sx[ckb_pkg::POS_W-1] && (pos.sx < $signed(ckb_pkg::POS_W'(SCREEN_WIDTH)));
    in_y = !pos.sy[ckb_pkg::POS_W-1] && (pos.sy < $signed(ckb_pkg::POS_W'(SCREEN_HEIGHT)));
    hit  = (pixel != ckb_pkg::TRANSPARENT) && in_x && in_y;
    prod = PW'($unsigned(pos.sy)) * PW'(SCREEN_WIDTH) + PW'($unsigned(pos.sx));
    addr = prod[ckb_pkg::ADDR_W-1:0];
  end

endmodule

FILE: rtl/color_key_sprite_blit_clip_top.sv
// ----------------------------------------------------------------------------
// color_key_sprite_blit_clip_top
// Color-keyed square sprite blitter with clipping to the screen.
// ----------------------------------------------------------------------------
// Sprite pixels arrive on in_ch in row-major order, one item per pixel. The
// item with start_req set latches the origin and side length and restarts
// the column and row counters. Each pixel whose color is nonzero and whose
// screen position falls inside the screen gives one frame-buffer write item
// on out_ch with its address (row times screen width plus column) and color;
// every other pixel is dropped, but still advances the counters.
// An item is registered on acceptance; its write enters the output register
// once that register is free and is then offered on out_ch.
// One pixel is taken every cycle unless a hit pixel waits on a stalled write;
// the rate is set by the single position/clip stage.
// When out_ch stalls, the output register holds the write and the input
// register still takes one pixel; dropped pixels keep draining. in_ch.ready
// falls only while a write waits in the output register and the next pixel
// also needs it. Reset clears both registers and sets origin 0,0, size 1.
// ----------------------------------------------------------------------------
module color_key_sprite_blit_clip_top #(
  parameter int SCREEN_WIDTH  = 512,
  parameter int SCREEN_HEIGHT = 200,
  parameter int MAX_SPRITE    = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  ckb_pix_if.sink  in_ch,
  ckb_wr_if.source out_ch
);

  logic                         s1_valid_r;
  ckb_pkg::pix_t                s1_data_r;
  logic                         out_valid_r;
  logic [ckb_pkg::ADDR_W-1:0]   out_addr_r;
  logic [ckb_pkg::PIXEL_W-1:0]  out_data_r;
  ckb_pkg::pos_t                pos;
  logic                         hit;
  logic [ckb_pkg::ADDR_W-1:0]   addr;
  logic                         out_free, s1_go, take;

  ckb_tracker #(.MAX_SPRITE(MAX_SPRITE)) u_tracker (
    .clk  (clk),
    .rst_n(rst_n),
    .step (s1_go),
    .pix  (s1_data_r),
    .pos  (pos)
  );

  ckb_clip #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_clip (
    .pos  (pos),
    .pixel(s1_data_r.pixel),
    .hit  (hit),
    .addr (addr)
  );

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_go       = s1_valid_r && (!hit || out_free);
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign take        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_data_r.pixel       <= in_ch.pixel;
      s1_data_r.start_req   <= in_ch.start_req;
      s1_data_r.origin_x    <= in_ch.origin_x;
      s1_data_r.origin_y    <= in_ch.origin_y;
      s1_data_r.sprite_size <= in_ch.sprite_size;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r && hit) begin
      out_addr_r <= addr;
      out_data_r <= s1_data_r.pixel;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.write_address = out_addr_r;
  assign out_ch.write_data    = out_data_r;

endmodule

FILE: rtl/ckb_checker.sv
// ----------------------------------------------------------------------------
// ckb_checker
// Port-level checks for the sprite blitter, bound to the top level.
// ----------------------------------------------------------------------------
module ckb_checker #(
  parameter int SCREEN_WIDTH  = 512,
  parameter int SCREEN_HEIGHT = 200
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ckb_pkg::ADDR_W-1:0]  write_address,
  input logic [ckb_pkg::PIXEL_W-1:0] write_data
);

  localparam longint AREA = longint'(SCREEN_WIDTH) * longint'(SCREEN_HEIGHT);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(write_address)
      && $stable(write_data))
    else $error("Write item changed while stalled.");

  a_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> write_data != ckb_pkg::TRANSPARENT)
    else $error("Transparent pixel was written.");

  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (64'(write_address) < 64'(AREA)))
    else $error("Write address lies outside the screen.");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("Input stalled while the output was free.");

endmodule

bind color_key_sprite_blit_clip_top ckb_checker #(
  .SCREEN_WIDTH (SCREEN_WIDTH),
  .SCREEN_HEIGHT(SCREEN_HEIGHT)
) u_ckb_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .write_address(out_ch.write_address),
  .write_data   (out_ch.write_data)
);
